@@ design/slfw_pkg.sv @@
// Shared types, codes and sizes of the segment LCD serial frame writer.
package slfw_pkg;

    // Field widths of one input item and one result item.
    localparam int OP_W     = 3;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 8;
    localparam int BIDX_W   = 2;
    localparam int BITS_W   = 9;
    localparam int LEN_W    = 4;
    localparam int NIBBLE_W = 4;

    // Default size of the display shadow in bytes.
    localparam int SHADOW_BYTES_DEF = 16;

    // Entries of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Operation codes on the input channel.
    localparam logic [OP_W-1:0] OP_COMMAND = 3'd0;
    localparam logic [OP_W-1:0] OP_NIBBLE  = 3'd1;
    localparam logic [OP_W-1:0] OP_BYTE    = 3'd2;
    localparam logic [OP_W-1:0] OP_BIT     = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;
    localparam logic [OP_W-1:0] OP_REFRESH = 3'd5;

    // Work kinds handed from the front to the back.
    localparam int KIND_W = 3;
    localparam logic [KIND_W-1:0] K_COMMAND = 3'd0;
    localparam logic [KIND_W-1:0] K_NIBBLE  = 3'd1;
    localparam logic [KIND_W-1:0] K_BYTE    = 3'd2;
    localparam logic [KIND_W-1:0] K_BIT     = 3'd3;
    localparam logic [KIND_W-1:0] K_CLEAR   = 3'd4;
    localparam logic [KIND_W-1:0] K_REFRESH = 3'd5;

    // One classified item waiting for the back.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] data;
        logic [BIDX_W-1:0] bit_index;
        logic              bit_value;
    } t_cmd;

endpackage

@@ design/slfw_if.sv @@
// Handshake interfaces for input items and output chunks.
interface slfw_item_if;
    import slfw_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] data;
    logic [BIDX_W-1:0] bit_index;
    logic              bit_value;

    modport source (output valid, op, address, data, bit_index, bit_value, input ready);
    modport sink   (input valid, op, address, data, bit_index, bit_value, output ready);
endinterface

interface slfw_chunk_if;
    import slfw_pkg::*;

    logic              valid;
    logic              ready;
    logic [BITS_W-1:0] chunk_bits;
    logic [LEN_W-1:0]  chunk_length;
    logic              frame_last;

    modport source (output valid, chunk_bits, chunk_length, frame_last, input ready);
    modport sink   (input valid, chunk_bits, chunk_length, frame_last, output ready);
endinterface

@@ design/segment_lcd_serial_frame_writer_core.sv @@
// Segment LCD serial frame writer: item front end, queue and frame sequencer.
// Each accepted item of a known op code becomes one frame for the display controller,
// given out as chunks in wire order; writes and clear all also update the internal
// display shadow. The front end takes an item in any cycle the two-entry queue has
// room; op codes 6 and 7 are accepted and dropped. The back sequencer picks up a
// queued item in its idle state and then emits one chunk per cycle while the output
// side takes them: two chunks for a command, three for a nibble, byte or bit write,
// and SHADOW_BYTES + 2 (18 by default) for clear all and refresh. The chunk rate
// of the sequencer and the output register set the throughput. The shadow is zero
// after reset with no clearing pass; per-entry valid bits mark written nibbles.
module segment_lcd_serial_frame_writer_core #(
    parameter int SHADOW_BYTES = slfw_pkg::SHADOW_BYTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    slfw_item_if.sink     i_item,
    slfw_chunk_if.source  o_chunk
);
    import slfw_pkg::*;

    logic push;
    logic pop;
    logic full;
    logic empty;
    t_cmd front_cmd;
    t_cmd head_cmd;

    // Accept and classify.
    slfw_front u_front (
        .i_item (i_item),
        .i_full (full),
        .o_push (push),
        .o_cmd  (front_cmd)
    );

    // Decoupling queue.
    slfw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_cmd   (head_cmd)
    );

    // Frame sequencer and display shadow.
    slfw_back #(
        .SHADOW_BYTES (SHADOW_BYTES)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_cmd   (head_cmd),
        .o_pop   (pop),
        .o_chunk (o_chunk)
    );

endmodule

@@ design/slfw_front.sv @@
// Front end: accepts items, drops unused op codes and classifies the rest.
module slfw_front (
    slfw_item_if.sink        i_item,
    input  logic             i_full,
    output logic             o_push,
    output slfw_pkg::t_cmd   o_cmd
);
    import slfw_pkg::*;

    logic w_known;

    // An item is taken whenever the queue has room; unknown codes are dropped.
    assign i_item.ready = !i_full;

    // Decode the op code into a work kind and trim the data it does not use.
    always_comb begin
        w_known         = 1'b1;
        o_cmd.kind      = K_COMMAND;
        o_cmd.address   = i_item.address;
        o_cmd.data      = i_item.data;
        o_cmd.bit_index = i_item.bit_index;
        o_cmd.bit_value = i_item.bit_value;
        unique case (i_item.op)
            OP_COMMAND: o_cmd.kind = K_COMMAND;
            OP_NIBBLE: begin
                o_cmd.kind = K_NIBBLE;
                o_cmd.data = {{(DATA_W-NIBBLE_W){1'b0}}, i_item.data[NIBBLE_W-1:0]};
            end
            OP_BYTE:    o_cmd.kind = K_BYTE;
            OP_BIT:     o_cmd.kind = K_BIT;
            OP_CLEAR:   o_cmd.kind = K_CLEAR;
            OP_REFRESH: o_cmd.kind = K_REFRESH;
            default:    w_known = 1'b0;
        endcase
    end

    assign o_push = i_item.valid && !i_full && w_known;

endmodule

@@ design/slfw_queue.sv @@
// Short queue of classified items between the front and the back.
module slfw_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  slfw_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output slfw_pkg::t_cmd o_cmd
);
    import slfw_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_slot[r_rd_ptr];

    // Pointers wrap at the depth, which need not be a power of two.
    always_comb begin
        n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

@@ design/slfw_back.sv @@
// Back end: frame sequencer, display shadow and output register.
module slfw_back #(
    parameter int SHADOW_BYTES = slfw_pkg::SHADOW_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  slfw_pkg::t_cmd   i_cmd,
    output logic             o_pop,
    slfw_chunk_if.source     o_chunk
);
    import slfw_pkg::*;

    localparam int RW = (SHADOW_BYTES > 1) ? $clog2(SHADOW_BYTES) : 1;
    localparam int CMP_W = 6;

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MODE = 3'd1;
    localparam logic [2:0] S_ADDR = 3'd2;
    localparam logic [2:0] S_DATA = 3'd3;
    localparam logic [2:0] S_WALK = 3'd4;

    // Mode prefixes of the two frame types.
    localparam logic [BITS_W-1:0] MODE_COMMAND = 9'd4;
    localparam logic [BITS_W-1:0] MODE_WRITE   = 9'd5;

    typedef logic [RW-1:0] t_row;

    function automatic logic [NIBBLE_W-1:0] rev4(input logic [NIBBLE_W-1:0] v);
        logic [NIBBLE_W-1:0] r;
        for (int k = 0; k < NIBBLE_W; k++) begin
            r[k] = v[NIBBLE_W-1-k];
        end
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] rev8(input logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] r;
        for (int k = 0; k < DATA_W; k++) begin
            r[k] = v[DATA_W-1-k];
        end
        return r;
    endfunction

    logic [2:0]          r_state, n_state;
    t_cmd                r_cmd;
    logic                r_ok;
    t_row                r_row, n_row;
    logic                r_o_valid;
    logic [BITS_W-1:0]   r_o_bits;
    logic [LEN_W-1:0]    r_o_len;
    logic                r_o_last;

    // Shadow in two banks of nibbles, even and odd addresses, one row per byte.
    logic [NIBBLE_W-1:0] r_mem_e [SHADOW_BYTES];
    logic [NIBBLE_W-1:0] r_mem_o [SHADOW_BYTES];
    logic [NIBBLE_W-1:0] r_rd_e;
    logic [NIBBLE_W-1:0] r_rd_o;
    logic [SHADOW_BYTES-1:0] r_ve;
    logic [SHADOW_BYTES-1:0] r_vo;

    logic                out_free;
    logic                load;
    logic [BITS_W-1:0]   ld_bits;
    logic [LEN_W-1:0]    ld_len;
    logic                ld_last;
    logic                we_e, we_o;
    t_row                wr_row_e, wr_row_o;
    logic [NIBBLE_W-1:0] wr_e, wr_o;
    logic                clr_valid;
    logic                in_ok;
    logic                walk_kind;
    logic                walk_last;
    logic                hi_ok;
    logic [NIBBLE_W-1:0] cur_e, cur_o, cur_nib, bit_nib;
    logic [DATA_W-1:0]   walk_byte;

    assign out_free = !r_o_valid || o_chunk.ready;
    assign o_pop    = (r_state == S_IDLE) && !i_empty;

    // Range checks on the addressed row and on the row above it.
    assign in_ok = (CMP_W'(i_cmd.address[ADDR_W-1:1]) < CMP_W'(SHADOW_BYTES));
    assign hi_ok = (r_cmd.address != '1) &&
                   ((CMP_W'(r_cmd.address[ADDR_W-1:1]) + CMP_W'(1)) < CMP_W'(SHADOW_BYTES));
    assign walk_kind = (r_cmd.kind == K_CLEAR) || (r_cmd.kind == K_REFRESH);
    assign walk_last = (r_row == RW'(SHADOW_BYTES - 1));

    // Current shadow contents at the sequencer's row; a row never written reads zero.
    assign cur_e   = r_ve[r_row] ? r_rd_e : '0;
    assign cur_o   = r_vo[r_row] ? r_rd_o : '0;
    assign cur_nib = !r_ok ? '0 : (r_cmd.address[0] ? cur_o : cur_e);

    // Read-modify-write of one bit of the addressed nibble.
    always_comb begin
        bit_nib = cur_nib;
        bit_nib[r_cmd.bit_index] = r_cmd.bit_value;
    end

    assign walk_byte = (r_cmd.kind == K_CLEAR) ? '0 : {cur_o, cur_e};

    // Sequencer: one chunk per cycle into the output register while it is free to load.
    always_comb begin
        n_state   = r_state;
        n_row     = r_row;
        load      = 1'b0;
        ld_bits   = '0;
        ld_len    = '0;
        ld_last   = 1'b0;
        we_e      = 1'b0;
        we_o      = 1'b0;
        wr_row_e  = r_row;
        wr_row_o  = r_row;
        wr_e      = r_cmd.data[NIBBLE_W-1:0];
        wr_o      = r_cmd.data[NIBBLE_W-1:0];
        clr_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    n_state = S_MODE;
                    if ((i_cmd.kind == K_CLEAR) || (i_cmd.kind == K_REFRESH) || !in_ok) begin
                        n_row = '0;
                    end else begin
                        n_row = t_row'(i_cmd.address[ADDR_W-1:1]);
                    end
                    clr_valid = (i_cmd.kind == K_CLEAR);
                end
            end
            S_MODE: begin
                if (out_free) begin
                    load    = 1'b1;
                    ld_len  = LEN_W'(3);
                    if (r_cmd.kind == K_COMMAND) begin
                        ld_bits = MODE_COMMAND;
                        n_state = S_DATA;
                    end else begin
                        ld_bits = MODE_WRITE;
                        n_state = S_ADDR;
                    end
                end
            end
            S_ADDR: begin
                if (out_free) begin
                    load   = 1'b1;
                    ld_len = LEN_W'(6);
                    if (walk_kind) begin
                        ld_bits = '0;
                        n_state = S_WALK;
                    end else begin
                        ld_bits = BITS_W'(r_cmd.address);
                        n_state = S_DATA;
                    end
                end
            end
            S_DATA: begin
                if (out_free) begin
                    load    = 1'b1;
                    ld_last = 1'b1;
                    n_state = S_IDLE;
                    case (r_cmd.kind)
                        K_COMMAND: begin
                            ld_bits = {r_cmd.data, 1'b0};
                            ld_len  = LEN_W'(9);
                        end
                        K_BYTE: begin
                            ld_bits = BITS_W'(rev8(r_cmd.data));
                            ld_len  = LEN_W'(8);
                            if (r_cmd.address[0]) begin
                                we_o     = r_ok;
                                we_e     = hi_ok;
                                wr_row_e = r_row + 1'b1;
                                wr_e     = r_cmd.data[DATA_W-1:NIBBLE_W];
                            end else begin
                                we_e = r_ok;
                                we_o = r_ok;
                                wr_o = r_cmd.data[DATA_W-1:NIBBLE_W];
                            end
                        end
                        K_BIT: begin
                            ld_bits = BITS_W'(rev4(bit_nib));
                            ld_len  = LEN_W'(4);
                            we_e    = r_ok && !r_cmd.address[0];
                            we_o    = r_ok && r_cmd.address[0];
                            wr_e    = bit_nib;
                            wr_o    = bit_nib;
                        end
                        default: begin
                            ld_bits = BITS_W'(rev4(r_cmd.data[NIBBLE_W-1:0]));
                            ld_len  = LEN_W'(4);
                            we_e    = r_ok && !r_cmd.address[0];
                            we_o    = r_ok && r_cmd.address[0];
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (out_free) begin
                    load    = 1'b1;
                    ld_bits = BITS_W'(rev8(walk_byte));
                    ld_len  = LEN_W'(8);
                    ld_last = walk_last;
                    if (walk_last) begin
                        n_row   = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_row = r_row + 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state, output valid and shadow valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_row     <= '0;
            r_o_valid <= 1'b0;
            r_ve      <= '0;
            r_vo      <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            if (load) begin
                r_o_valid <= 1'b1;
            end else if (o_chunk.ready) begin
                r_o_valid <= 1'b0;
            end
            if (clr_valid) begin
                r_ve <= '0;
                r_vo <= '0;
            end else begin
                if (we_e) begin
                    r_ve[wr_row_e] <= 1'b1;
                end
                if (we_o) begin
                    r_vo[wr_row_o] <= 1'b1;
                end
            end
        end
    end

    // Payload registers: held item and output chunk.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
            r_ok  <= in_ok;
        end
        if (load) begin
            r_o_bits <= ld_bits;
            r_o_len  <= ld_len;
            r_o_last <= ld_last;
        end
    end

    // Even bank: one write and one registered read at the next row.
    always_ff @(posedge i_clk) begin
        if (we_e) begin
            r_mem_e[wr_row_e] <= wr_e;
        end
        r_rd_e <= r_mem_e[n_row];
    end

    // Odd bank: one write and one registered read at the next row.
    always_ff @(posedge i_clk) begin
        if (we_o) begin
            r_mem_o[wr_row_o] <= wr_o;
        end
        r_rd_o <= r_mem_o[n_row];
    end

    assign o_chunk.valid        = r_o_valid;
    assign o_chunk.chunk_bits   = r_o_bits;
    assign o_chunk.chunk_length = r_o_len;
    assign o_chunk.frame_last   = r_o_last;

endmodule

@@ tb/segment_lcd_serial_frame_writer_core_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the segment LCD serial frame writer core.
module segment_lcd_serial_frame_writer_core_tb;
    import slfw_pkg::*;

    // Op codes that the block accepts and drops.
    localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;

    localparam int NIBBLES       = 2 * SHADOW_BYTES_DEF;
    localparam int RANDOM_ITEMS  = 90;
    localparam int DRAIN_LIMIT   = 20000;

    // One chunk of a frame as it appears on the output channel.
    typedef struct packed {
        logic [BITS_W-1:0] bits;
        logic [LEN_W-1:0]  len;
        logic              last;
    } t_chunk;

    logic i_clk;
    logic i_rst_n;

    slfw_item_if  item_bus ();
    slfw_chunk_if chunk_bus ();

    segment_lcd_serial_frame_writer_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_bus),
        .o_chunk (chunk_bus)
    );

    // Predicted display memory and the chunks still owed by the block.
    logic [NIBBLE_W-1:0] lcd_shadow [NIBBLES];
    t_chunk              pending_chunks [$];

    int unsigned stall_percent = 19;
    int unsigned fail_count    = 0;
    int unsigned items_sent    = 0;
    int unsigned chunks_seen   = 0;
    int unsigned op_count [8];

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog against a hung handshake.
    initial begin
        #3_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Serial order puts bit 0 of the value first on the wire, so at the top.
    function automatic logic [BITS_W-1:0] wire_order(input logic [7:0] value, input int n);
        logic [BITS_W-1:0] r;
        r = '0;
        for (int i = 0; i < n; i++) begin
            r = {r[BITS_W-2:0], value[i]};
        end
        return r;
    endfunction

    function automatic void add_chunk(input logic [BITS_W-1:0] bits,
                                      input logic [LEN_W-1:0] len, input logic last);
        t_chunk c;
        c.bits = bits;
        c.len  = len;
        c.last = last;
        pending_chunks.push_back(c);
    endfunction

    // Mode, address and one nibble; the shadow takes the nibble.
    function automatic void nibble_frame(input logic [ADDR_W-1:0] addr,
                                         input logic [NIBBLE_W-1:0] nib);
        add_chunk(9'd5, 4'd3, 1'b0);
        add_chunk(BITS_W'(addr), 4'd6, 1'b0);
        add_chunk(wire_order(8'(nib), 4), 4'd4, 1'b1);
        lcd_shadow[addr] = nib;
    endfunction

    // Walk the whole shadow from address 0, two nibbles per byte chunk.
    function automatic void memory_walk(input logic clear);
        logic [7:0] byte_val;
        add_chunk(9'd5, 4'd3, 1'b0);
        add_chunk(9'd0, 4'd6, 1'b0);
        for (int i = 0; i < SHADOW_BYTES_DEF; i++) begin
            if (clear) begin
                lcd_shadow[2*i]   = '0;
                lcd_shadow[2*i+1] = '0;
            end
            byte_val = {lcd_shadow[2*i+1], lcd_shadow[2*i]};
            add_chunk(wire_order(byte_val, 8), 4'd8, i == SHADOW_BYTES_DEF - 1);
        end
    endfunction

    // Expected frame of one accepted item, with its effect on the shadow.
    function automatic void predict_frame(input logic [OP_W-1:0] op,
                                          input logic [ADDR_W-1:0] addr,
                                          input logic [DATA_W-1:0] data,
                                          input logic [BIDX_W-1:0] bidx, input logic bval);
        logic [NIBBLE_W-1:0] nib;
        case (op)
            OP_COMMAND: begin
                add_chunk(9'd4, 4'd3, 1'b0);
                add_chunk({data, 1'b0}, 4'd9, 1'b1);
            end
            OP_NIBBLE: nibble_frame(addr, data[3:0]);
            OP_BYTE: begin
                add_chunk(9'd5, 4'd3, 1'b0);
                add_chunk(BITS_W'(addr), 4'd6, 1'b0);
                add_chunk(wire_order(data, 8), 4'd8, 1'b1);
                lcd_shadow[addr] = data[3:0];
                // The top address has no neighbor for the high nibble.
                if (addr < 5'd31) begin
                    lcd_shadow[addr + 1] = data[7:4];
                end
            end
            OP_BIT: begin
                nib       = lcd_shadow[addr];
                nib[bidx] = bval;
                nibble_frame(addr, nib);
            end
            OP_CLEAR:   memory_walk(1'b1);
            OP_REFRESH: memory_walk(1'b0);
            default: ;
        endcase
    endfunction

    function automatic void check_field(input string name, input int unsigned expected_val,
                                        input int unsigned actual_val);
        if (expected_val != actual_val) begin
            fail_count++;
            $display("%0t: chunk %0d %s mismatch: expected %0h, actual %0h",
                     $time, chunks_seen, name, expected_val, actual_val);
        end
    endfunction

    // Output side: check each accepted chunk, then pick the next ready.
    always @(posedge i_clk) begin
        t_chunk expected_chunk;
        if (i_rst_n && chunk_bus.valid && chunk_bus.ready) begin
            if (pending_chunks.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected chunk: expected none, actual %0h/%0d/%0b",
                         $time, chunk_bus.chunk_bits, chunk_bus.chunk_length,
                         chunk_bus.frame_last);
            end else begin
                expected_chunk = pending_chunks.pop_front();
                check_field("chunk_bits", expected_chunk.bits, chunk_bus.chunk_bits);
                check_field("chunk_length", expected_chunk.len, chunk_bus.chunk_length);
                check_field("frame_last", expected_chunk.last, chunk_bus.frame_last);
            end
            chunks_seen++;
        end
        chunk_bus.ready <= ($urandom_range(99) >= stall_percent);
    end

    // Offer one item after a random gap and hold it until it is taken.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] data, input logic [BIDX_W-1:0] bidx,
                             input logic bval);
        while ($urandom_range(99) < stall_percent) begin
            item_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_bus.valid     <= 1'b1;
        item_bus.op        <= op;
        item_bus.address   <= addr;
        item_bus.data      <= data;
        item_bus.bit_index <= bidx;
        item_bus.bit_value <= bval;
        do @(posedge i_clk); while (!item_bus.ready);
        predict_frame(op, addr, data, bidx, bval);
        op_count[op]++;
        items_sent++;
    endtask

    // Hold off the sender until every owed chunk has arrived.
    task automatic wait_drained();
        int unsigned cycles;
        cycles = 0;
        item_bus.valid <= 1'b0;
        while (pending_chunks.size() != 0 && cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        if (pending_chunks.size() != 0) begin
            fail_count++;
            $display("%0t: drain timeout: expected 0 pending chunks, actual %0d",
                     $time, pending_chunks.size());
        end
    endtask

    task automatic test_commands();
        send_item(OP_COMMAND, 5'd0, 8'h00, 2'd0, 1'b0);
        send_item(OP_COMMAND, 5'd31, 8'hFF, 2'd3, 1'b1);
        send_item(OP_COMMAND, 5'd9, 8'hA5, 2'd1, 1'b0);
    endtask

    task automatic test_nibble_writes();
        // High data bits must be ignored.
        send_item(OP_NIBBLE, 5'd0, 8'hF0, 2'd0, 1'b0);
        send_item(OP_NIBBLE, 5'd31, 8'h0F, 2'd0, 1'b0);
        send_item(OP_NIBBLE, 5'd5, 8'h3A, 2'd0, 1'b0);
    endtask

    task automatic test_byte_writes();
        // At the top address the high nibble is lost from the shadow.
        send_item(OP_BYTE, 5'd31, 8'hC3, 2'd0, 1'b0);
        send_item(OP_BYTE, 5'd0, 8'hFF, 2'd0, 1'b0);
        send_item(OP_BYTE, 5'd30, 8'h5A, 2'd0, 1'b0);
    endtask

    task automatic test_bit_writes();
        send_item(OP_BIT, 5'd31, 8'h00, 2'd3, 1'b0);
        send_item(OP_BIT, 5'd31, 8'h00, 2'd0, 1'b0);
        send_item(OP_BIT, 5'd7, 8'hFF, 2'd0, 1'b1);
        send_item(OP_BIT, 5'd0, 8'h00, 2'd3, 1'b0);
        send_item(OP_BIT, 5'd12, 8'h00, 2'd2, 1'b1);
    endtask

    task automatic test_memory_walks();
        send_item(OP_REFRESH, 5'd0, 8'h00, 2'd0, 1'b0);
        send_item(OP_CLEAR, 5'd17, 8'hFF, 2'd3, 1'b1);
        send_item(OP_REFRESH, 5'd31, 8'hFF, 2'd3, 1'b1);
    endtask

    task automatic test_unused_ops();
        // The two unused ops must produce no chunks and leave the shadow alone.
        send_item(OP_UNUSED_6, 5'd3, 8'hFF, 2'd1, 1'b1);
        send_item(OP_UNUSED_7, 5'd4, 8'h0F, 2'd2, 1'b1);
        send_item(OP_REFRESH, 5'd0, 8'h00, 2'd0, 1'b0);
    endtask

    // Random mix, weighted toward short writes since walks are long.
    task automatic test_random_mix();
        int unsigned counted;
        int unsigned pick;
        logic [OP_W-1:0] op;
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 3) begin
                op = $urandom_range(1) ? OP_UNUSED_7 : OP_UNUSED_6;
            end else if (pick < 9) begin
                op = OP_CLEAR;
            end else if (pick < 17) begin
                op = OP_REFRESH;
            end else begin
                op = OP_W'($urandom_range(3));
            end
            // A stretch without any idling on either side.
            stall_percent = (counted >= 40 && counted < 70) ? 0 : 19;
            send_item(op, ADDR_W'($urandom_range(31)), DATA_W'($urandom_range(255)),
                      BIDX_W'($urandom_range(3)), 1'($urandom_range(1)));
            if (op != OP_UNUSED_6 && op != OP_UNUSED_7) begin
                counted++;
            end
            if (counted == 85) begin
                wait_drained();
            end
        end
        stall_percent = 19;
    endtask

    // Test sequence.
    initial begin
        for (int i = 0; i < NIBBLES; i++) begin
            lcd_shadow[i] = '0;
        end
        for (int i = 0; i < 8; i++) begin
            op_count[i] = 0;
        end
        i_rst_n            <= 1'b0;
        item_bus.valid     <= 1'b0;
        item_bus.op        <= OP_COMMAND;
        item_bus.address   <= '0;
        item_bus.data      <= '0;
        item_bus.bit_index <= '0;
        item_bus.bit_value <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_commands();
        test_nibble_writes();
        test_byte_writes();
        test_bit_writes();
        test_memory_walks();
        test_unused_ops();
        wait_drained();
        test_random_mix();

        wait_drained();
        repeat (40) @(posedge i_clk);

        $display("Sent %0d items: %0d commands, %0d nibble, %0d byte, %0d bit writes,",
                 items_sent, op_count[OP_COMMAND], op_count[OP_NIBBLE], op_count[OP_BYTE],
                 op_count[OP_BIT]);
        $display("%0d clears, %0d refreshes, %0d dropped ops; %0d chunks checked.",
                 op_count[OP_CLEAR], op_count[OP_REFRESH],
                 op_count[OP_UNUSED_6] + op_count[OP_UNUSED_7], chunks_seen);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
